// File: rtl/core/rdsm_pkg.sv
`timescale 1ns / 1ps

package rdsm_pkg;

    // Default size of the pattern token store
    localparam int DEFAULT_MAX_TOKENS = 32;

    // Pattern metacharacters
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    // Request mode codes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_TEXT   = 2'd2;
    localparam logic [1:0] MODE_END    = 2'd3;

    // Decoupling queue between front and back
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_FILL_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_TEXT,
        OP_END
    } t_op;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic matched;
        logic pattern_invalid;
    } t_out_item;

    // Classified request as held in the queue
    typedef struct packed {
        t_op        op;
        logic [7:0] symbol;
        logic       is_star;
        logic       is_dot;
    } t_qent;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qhead;

endpackage

// File: rtl/core/regex_dot_star_matcher_unit.sv
`timescale 1ns / 1ps
// Channel | valid   | stall   | payload               | direction
// in      | i_valid | o_stall | i_item (t_in_item)    | request into the matcher
// out     | o_valid | i_stall | o_item (t_out_item)   | match result, end of text only
//
// One request per cycle sustained while the queue has room and no end-of-text
// request waits on a stalled result; the end-of-text result is registered.
// A text byte is retired by a MaxTokens-step ripple through the star-closure
// chain of the position lanes; that chain sets the clock.
// Synchronous active-low reset: empty pattern, valid, active set {0}, queue empty.
// A stalled result holds in the output register; only an end-of-text request waits
// on it, requests ahead of it keep flowing and those behind it back up in the queue.

module regex_dot_star_matcher_unit import rdsm_pkg::*; #(
    parameter int MaxTokens = DEFAULT_MAX_TOKENS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    // front to back: head of the two-entry queue
    t_qhead head;
    logic   pop;

    // front end: accepts and classifies requests, buffers them
    rdsm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_head  (head),
        .i_pop   (pop)
    );

    // back end: token store, active position set, result register
    rdsm_back #(
        .MaxTokens (MaxTokens)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_valid),
        .o_out       (o_item),
        .i_stall     (i_stall)
    );

`ifndef SYNTHESIS
    // the back end only consumes a queued request
    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("pop without queued request");

    // an invalid pattern never reports a match
    a_invalid_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.matched) |-> !o_item.pattern_invalid)
        else $error("match reported for invalid pattern");

    // an end-of-text request cannot be consumed while a result is stuck
    a_end_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && head.valid && (head.ent.op == OP_END)) |-> !pop)
        else $error("result overwritten while stalled");

    // first cycle out of reset leaves both channels quiet
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!o_valid && !o_stall))
        else $error("channels not idle after reset");
`endif

endmodule

// File: rtl/core/rdsm_front.sv
`timescale 1ns / 1ps

module rdsm_front import rdsm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_stall,
    output t_qhead   o_head,
    input  logic     i_pop
);

    t_qent               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_FILL_W-1:0] r_fill;
    logic [Q_FILL_W-1:0] n_fill;
    t_qent               n_ent;
    logic                push;
    logic                pop;

    // classify the incoming request
    always_comb begin
        case (i_item.mode)
            MODE_CLEAR:  n_ent.op = OP_CLEAR;
            MODE_APPEND: n_ent.op = OP_APPEND;
            MODE_TEXT:   n_ent.op = OP_TEXT;
            MODE_END:    n_ent.op = OP_END;
            default:     n_ent.op = OP_END;
        endcase
        n_ent.symbol  = i_item.symbol;
        n_ent.is_star = (i_item.symbol == STAR_BYTE);
        n_ent.is_dot  = (i_item.symbol == DOT_BYTE);
    end

    assign o_stall = (r_fill == Q_FILL_W'(Q_DEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_fill != '0);

    always_comb begin
        case ({push, pop})
            2'b10:   n_fill = r_fill + Q_FILL_W'(1);
            2'b01:   n_fill = r_fill - Q_FILL_W'(1);
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            if (pop)  r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr_ptr] <= n_ent;
    end

    assign o_head.valid = (r_fill != '0);
    assign o_head.ent   = r_q[r_rd_ptr];

endmodule

// File: rtl/core/rdsm_back.sv
`timescale 1ns / 1ps

module rdsm_back import rdsm_pkg::*; #(
    parameter int MaxTokens = DEFAULT_MAX_TOKENS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_qhead    i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_stall
);

    localparam int CNT_W = $clog2(MaxTokens + 1);

    // token store, flip-flops read in parallel by the position lanes
    logic [7:0]           r_byte [MaxTokens];
    logic [MaxTokens-1:0] r_wild;
    logic [MaxTokens-1:0] r_star;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_invalid;
    logic                 n_invalid;
    logic                 r_last_star;
    logic                 n_last_star;
    logic [MaxTokens:0]   r_active;
    logic [MaxTokens:0]   n_active;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [MaxTokens-1:0] mask;
    logic [MaxTokens-1:0] star_eff;
    logic [MaxTokens:0]   closed;
    logic [MaxTokens-1:0] hit;
    logic [MaxTokens:0]   stepped;
    logic                 out_free;
    logic                 tok_wr;
    logic                 star_wr;
    t_qent                ent;

    localparam logic [MaxTokens:0] ACTIVE_RST = {{MaxTokens{1'b0}}, 1'b1};

    assign ent      = i_head.ent;
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_head.valid && ((ent.op != OP_END) || out_free);

    // position lanes: closure ripple and per-token compare
    always_comb begin
        for (int i = 0; i < MaxTokens; i++) begin
            mask[i] = (CNT_W'(i) < r_count);
        end
        star_eff  = r_star & mask;
        closed[0] = r_active[0];
        for (int i = 0; i < MaxTokens; i++) begin
            closed[i+1] = r_active[i+1] | (closed[i] & star_eff[i]);
        end
        for (int i = 0; i < MaxTokens; i++) begin
            hit[i] = mask[i] && closed[i] && (r_wild[i] || (r_byte[i] == ent.symbol));
        end
        stepped = '0;
        for (int i = 0; i < MaxTokens; i++) begin
            if (hit[i]) begin
                if (r_star[i]) stepped[i] = 1'b1;
                else           stepped[i+1] = 1'b1;
            end
        end
    end

    always_comb begin
        n_count     = r_count;
        n_invalid   = r_invalid;
        n_last_star = r_last_star;
        n_active    = r_active;
        tok_wr      = 1'b0;
        star_wr     = 1'b0;
        if (o_pop) begin
            case (ent.op)
                OP_CLEAR: begin
                    n_count     = '0;
                    n_invalid   = 1'b0;
                    n_last_star = 1'b0;
                    n_active    = ACTIVE_RST;
                end
                OP_APPEND: begin
                    n_active = ACTIVE_RST;
                    if (!r_invalid) begin
                        if (ent.is_star) begin
                            if ((r_count == '0) || r_last_star) begin
                                n_invalid = 1'b1;
                            end else begin
                                star_wr     = 1'b1;
                                n_last_star = 1'b1;
                            end
                        end else if (r_count == CNT_W'(MaxTokens)) begin
                            n_invalid = 1'b1;
                        end else begin
                            tok_wr      = 1'b1;
                            n_count     = r_count + CNT_W'(1);
                            n_last_star = 1'b0;
                        end
                    end
                end
                OP_TEXT: n_active = stepped;
                OP_END:  n_active = ACTIVE_RST;
                default: n_active = r_active;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_invalid   <= 1'b0;
            r_last_star <= 1'b0;
            r_active    <= ACTIVE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_invalid   <= n_invalid;
            r_last_star <= n_last_star;
            r_active    <= n_active;
            if (o_pop && (ent.op == OP_END)) r_out_valid <= 1'b1;
            else if (!i_stall)               r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (ent.op == OP_END)) begin
            r_out.matched         <= !r_invalid && closed[r_count];
            r_out.pattern_invalid <= r_invalid;
        end
        for (int i = 0; i < MaxTokens; i++) begin
            if (tok_wr && (CNT_W'(i) == r_count)) begin
                r_byte[i] <= ent.symbol;
                r_wild[i] <= ent.is_dot;
                r_star[i] <= 1'b0;
            end
            if (star_wr && (CNT_W'(i + 1) == r_count)) begin
                r_star[i] <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
